@@ rtl/rvsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rvsc_pkg
// Shared constants, opcode/func codes and inter-module structs for the
// RV64 subset core.
// ----------------------------------------------------------------------------
package rvsc_pkg;

    localparam int XLEN       = 64;
    localparam int ILEN       = 32;
    localparam int NREGS      = 32;
    localparam int RIDX_W     = $clog2(NREGS);

    // Data memory depth in doublewords; a power of two, so the word index is
    // a plain slice of the byte address.
    localparam int DMEM_WORDS = 512;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);

    // Major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_OPIMM  = 7'd19;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_BRANCH = 7'd99;

    // ALU func3
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SRL = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // Branch func3
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;

    localparam logic [6:0] F7_SUB = 7'd32;

    // Result of the execute stage
    typedef struct packed {
        logic                wen;
        logic [RIDX_W-1:0]   rd;
        logic [XLEN-1:0]     wval;
        logic                is_load;
        logic                sen;
        logic [XLEN-1:0]     saddr;
        logic [XLEN-1:0]     sval;
        logic                taken;
        logic [ILEN-1:0]     npc;
        logic                unsup;
        logic [DMEM_AW-1:0]  midx;
    } t_exec_res;

    // Register file access
    typedef struct packed {
        logic                re;
        logic [RIDX_W-1:0]   ra1;
        logic [RIDX_W-1:0]   ra2;
        logic                we;
        logic [RIDX_W-1:0]   wa;
        logic [XLEN-1:0]     wd;
    } t_rf_req;

    // Data memory access
    typedef struct packed {
        logic                re;
        logic                we;
        logic [DMEM_AW-1:0]  idx;
        logic [XLEN-1:0]     wd;
    } t_dmem_req;

endpackage

@@ rtl/rvsc_regfile.sv @@
// ----------------------------------------------------------------------------
// rvsc_regfile
// 32 x 64 register file, two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset; x0 is never written.
// ----------------------------------------------------------------------------
module rvsc_regfile (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rvsc_pkg::t_rf_req          i_req,
    output logic [rvsc_pkg::XLEN-1:0]  o_rs1_val,
    output logic [rvsc_pkg::XLEN-1:0]  o_rs2_val
);

    logic [rvsc_pkg::XLEN-1:0]  r_mem [rvsc_pkg::NREGS];
    logic [rvsc_pkg::NREGS-1:0] r_vld;
    logic [rvsc_pkg::XLEN-1:0]  r_q1;
    logic [rvsc_pkg::XLEN-1:0]  r_q2;
    logic                       r_q1_vld;
    logic                       r_q2_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        if (i_req.re) begin
            r_q1 <= r_mem[i_req.ra1];
            r_q2 <= r_mem[i_req.ra2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_q1_vld <= 1'b0;
            r_q2_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.wa] <= 1'b1;
            end
            if (i_req.re) begin
                r_q1_vld <= r_vld[i_req.ra1];
                r_q2_vld <= r_vld[i_req.ra2];
            end
        end
    end

    assign o_rs1_val = r_q1_vld ? r_q1 : '0;
    assign o_rs2_val = r_q2_vld ? r_q2 : '0;

endmodule

@@ rtl/rvsc_dmem.sv @@
// ----------------------------------------------------------------------------
// rvsc_dmem
// Doubleword data memory, one port, registered read. After reset a sweep
// writes zero to every word, one per cycle, with busy held high.
// ----------------------------------------------------------------------------
module rvsc_dmem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rvsc_pkg::t_dmem_req        i_req,
    output logic [rvsc_pkg::XLEN-1:0]  o_rdata,
    output logic                       o_busy
);

    localparam logic [rvsc_pkg::DMEM_AW-1:0] LAST_IDX =
        rvsc_pkg::DMEM_AW'(rvsc_pkg::DMEM_WORDS - 1);

    logic [rvsc_pkg::XLEN-1:0]    r_mem [rvsc_pkg::DMEM_WORDS];
    logic [rvsc_pkg::XLEN-1:0]    r_q;
    logic                         r_clr_busy;
    logic [rvsc_pkg::DMEM_AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.idx] <= i_req.wd;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.idx];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_clr_busy;

endmodule

@@ rtl/rvsc_exec.sv @@
// ----------------------------------------------------------------------------
// rvsc_exec
// Decode and execute: ALU, effective address, branch compare, next pc.
// Load data is merged in the following stage.
// ----------------------------------------------------------------------------
module rvsc_exec (
    input  logic [rvsc_pkg::ILEN-1:0]  i_instr,
    input  logic [rvsc_pkg::ILEN-1:0]  i_pc,
    input  logic [rvsc_pkg::XLEN-1:0]  i_rs1_val,
    input  logic [rvsc_pkg::XLEN-1:0]  i_rs2_val,
    output rvsc_pkg::t_exec_res        o_res
);

    logic [6:0]                 opc;
    logic [2:0]                 f3;
    logic [6:0]                 f7;
    logic [4:0]                 rd;
    logic [rvsc_pkg::XLEN-1:0]  imm_i;
    logic [rvsc_pkg::XLEN-1:0]  imm_s;
    logic [rvsc_pkg::XLEN-1:0]  imm_b;
    logic [rvsc_pkg::XLEN-1:0]  opnd_b;
    logic [5:0]                 shamt;
    logic [rvsc_pkg::XLEN-1:0]  addr;
    logic                       is_sub;

    assign opc    = i_instr[6:0];
    assign rd     = i_instr[11:7];
    assign f3     = i_instr[14:12];
    assign f7     = i_instr[31:25];
    assign imm_i  = {{52{i_instr[31]}}, i_instr[31:20]};
    assign imm_s  = {{52{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b  = {{51{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                     i_instr[11:8], 1'b0};
    assign opnd_b = (opc == rvsc_pkg::OPC_OPIMM) ? imm_i : i_rs2_val;
    assign shamt  = opnd_b[5:0];
    assign is_sub = (opc == rvsc_pkg::OPC_OP) && (f7 == rvsc_pkg::F7_SUB);
    assign addr   = i_rs1_val + ((opc == rvsc_pkg::OPC_STORE) ? imm_s : imm_i);

    always_comb begin
        o_res      = '0;
        o_res.npc  = i_pc + 32'd4;
        o_res.midx = addr[3 +: rvsc_pkg::DMEM_AW];
        case (opc)
            rvsc_pkg::OPC_LOAD: begin
                o_res.wen     = 1'b1;
                o_res.is_load = 1'b1;
            end
            rvsc_pkg::OPC_OPIMM, rvsc_pkg::OPC_OP: begin
                o_res.wen = 1'b1;
                case (f3)
                    rvsc_pkg::F3_ADD: o_res.wval = is_sub ? i_rs1_val - opnd_b
                                                          : i_rs1_val + opnd_b;
                    rvsc_pkg::F3_SLL: o_res.wval = i_rs1_val << shamt;
                    rvsc_pkg::F3_XOR: o_res.wval = i_rs1_val ^ opnd_b;
                    rvsc_pkg::F3_SRL: o_res.wval = i_rs1_val >> shamt;
                    rvsc_pkg::F3_OR:  o_res.wval = i_rs1_val | opnd_b;
                    rvsc_pkg::F3_AND: o_res.wval = i_rs1_val & opnd_b;
                    default: begin
                        o_res.wen   = 1'b0;
                        o_res.unsup = 1'b1;
                    end
                endcase
            end
            rvsc_pkg::OPC_STORE: begin
                o_res.sen   = 1'b1;
                o_res.saddr = addr;
                o_res.sval  = i_rs2_val;
            end
            rvsc_pkg::OPC_BRANCH: begin
                case (f3)
                    rvsc_pkg::F3_BEQ: o_res.taken = (i_rs1_val == i_rs2_val);
                    rvsc_pkg::F3_BNE: o_res.taken = (i_rs1_val != i_rs2_val);
                    rvsc_pkg::F3_BLT: o_res.taken = ($signed(i_rs1_val) <
                                                     $signed(i_rs2_val));
                    rvsc_pkg::F3_BGE: o_res.taken = ($signed(i_rs1_val) >=
                                                     $signed(i_rs2_val));
                    default:          o_res.unsup = 1'b1;
                endcase
                if (o_res.taken) begin
                    o_res.npc = i_pc + imm_b[31:0];
                end
            end
            default: o_res.unsup = 1'b1;
        endcase
        // x0 destination: no write reported
        if (rd == 5'd0) begin
            o_res.wen  = 1'b0;
            o_res.wval = '0;
        end
        o_res.rd = o_res.wen ? rd : 5'd0;
    end

endmodule

@@ rtl/rv64_subset_single_cycle_core_unit.sv @@
// ----------------------------------------------------------------------------
// rv64_subset_single_cycle_core_unit
// RV64 subset core: ld, OP-IMM, sd, OP and conditional branches, with the
// register file and data memory held in synchronous RAMs.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+------------------------------------------
//   instr   | i_valid | o_ready | i_instr_word
//   result  | o_valid | i_ready | o_instr_pc .. o_unsupported (10 fields)
//
// One instruction per cycle sustained while results are accepted; a result
// is presented after register read, then execute and memory access.
// Operands are forwarded from the result stage and the last write-back, so
// dependent instructions, loads included, issue back to back.
// After reset o_ready stays low while data memory is cleared.
// A stalled result holds both stages; an empty execute stage still accepts.
// ----------------------------------------------------------------------------
module rv64_subset_single_cycle_core_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_instr_word,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_instr_pc,
    output logic [31:0]  o_next_pc,
    output logic         o_branch_taken,
    output logic         o_reg_write_en,
    output logic [4:0]   o_reg_write_index,
    output logic [63:0]  o_reg_write_value,
    output logic         o_store_en,
    output logic [63:0]  o_store_address,
    output logic [63:0]  o_store_value,
    output logic         o_unsupported
);

    logic                              in_acc;
    logic                              out_acc;
    logic                              s2_free;
    logic                              s1_free;
    logic                              s1_adv;
    logic                              dmem_busy;
    logic [4:0]                        rs1;
    logic [4:0]                        rs2;
    logic [rvsc_pkg::XLEN-1:0]         rf_q1;
    logic [rvsc_pkg::XLEN-1:0]         rf_q2;
    logic [rvsc_pkg::XLEN-1:0]         dmem_q;
    logic [rvsc_pkg::XLEN-1:0]         s2_val;
    logic [rvsc_pkg::XLEN-1:0]         opnd_a;
    logic [rvsc_pkg::XLEN-1:0]         opnd_b;
    rvsc_pkg::t_exec_res               ex_res;
    rvsc_pkg::t_rf_req                 rf_req;
    rvsc_pkg::t_dmem_req               dm_req;

    logic                              r_s1_v;
    logic [rvsc_pkg::ILEN-1:0]         r_s1_instr;
    logic                              r_s2_v;
    rvsc_pkg::t_exec_res               r_s2;
    logic [rvsc_pkg::ILEN-1:0]         r_s2_pc;
    logic [rvsc_pkg::ILEN-1:0]         r_pc;
    logic                              r_wb_v;
    logic [4:0]                        r_wb_idx;
    logic [rvsc_pkg::XLEN-1:0]         r_wb_val;
    logic [rvsc_pkg::ILEN-1:0]         n_pc;

    // Handshakes
    assign s2_free = !r_s2_v || i_ready;
    assign s1_free = !r_s1_v || s2_free;
    assign s1_adv  = r_s1_v && s2_free;
    assign o_ready = s1_free && !dmem_busy;
    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_s2_v && i_ready;

    // Result-stage write-back value
    assign s2_val = r_s2.is_load ? dmem_q : r_s2.wval;

    // Register file
    always_comb begin
        rf_req     = '0;
        rf_req.re  = in_acc;
        rf_req.ra1 = i_instr_word[19:15];
        rf_req.ra2 = i_instr_word[24:20];
        rf_req.we  = out_acc && r_s2.wen;
        rf_req.wa  = r_s2.rd;
        rf_req.wd  = s2_val;
    end

    rvsc_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rs1_val (rf_q1),
        .o_rs2_val (rf_q2)
    );

    // Operand forwarding: result stage first, then the last write-back
    // (which may have landed on the same edge as the RAM read).
    assign rs1 = r_s1_instr[19:15];
    assign rs2 = r_s1_instr[24:20];

    always_comb begin
        if (r_s2_v && r_s2.wen && (r_s2.rd == rs1)) begin
            opnd_a = s2_val;
        end else if (r_wb_v && (r_wb_idx == rs1)) begin
            opnd_a = r_wb_val;
        end else begin
            opnd_a = rf_q1;
        end
        if (r_s2_v && r_s2.wen && (r_s2.rd == rs2)) begin
            opnd_b = s2_val;
        end else if (r_wb_v && (r_wb_idx == rs2)) begin
            opnd_b = r_wb_val;
        end else begin
            opnd_b = rf_q2;
        end
    end

    rvsc_exec u_exec (
        .i_instr   (r_s1_instr),
        .i_pc      (r_pc),
        .i_rs1_val (opnd_a),
        .i_rs2_val (opnd_b),
        .o_res     (ex_res)
    );

    // Data memory: store writes and load reads as the instruction leaves
    // the execute stage.
    always_comb begin
        dm_req     = '0;
        dm_req.re  = s1_adv && ex_res.is_load;
        dm_req.we  = s1_adv && ex_res.sen;
        dm_req.idx = ex_res.midx;
        dm_req.wd  = ex_res.sval;
    end

    rvsc_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dm_req),
        .o_rdata (dmem_q),
        .o_busy  (dmem_busy)
    );

    assign n_pc = s1_adv ? ex_res.npc : r_pc;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_pc   <= '0;
            r_wb_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= in_acc;
            end
            if (s2_free) begin
                r_s2_v <= s1_adv;
            end
            r_pc <= n_pc;
            if (out_acc && r_s2.wen) begin
                r_wb_v <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_instr <= i_instr_word;
        end
        if (s1_adv) begin
            r_s2    <= ex_res;
            r_s2_pc <= r_pc;
        end
        if (out_acc && r_s2.wen) begin
            r_wb_idx <= r_s2.rd;
            r_wb_val <= s2_val;
        end
    end

    assign o_valid           = r_s2_v;
    assign o_instr_pc        = r_s2_pc;
    assign o_next_pc         = r_s2.npc;
    assign o_branch_taken    = r_s2.taken;
    assign o_reg_write_en    = r_s2.wen;
    assign o_reg_write_index = r_s2.rd;
    assign o_reg_write_value = r_s2.wen ? s2_val : '0;
    assign o_store_en        = r_s2.sen;
    assign o_store_address   = r_s2.saddr;
    assign o_store_value     = r_s2.sval;
    assign o_unsupported     = r_s2.unsup;

endmodule
